// ===== design/spc_pkg.sv =====
package spc_pkg;

    // Default data width of positions, errors and rates (Q24.8 at 32 bits)
    localparam int DATA_WIDTH_DEF = 32;

    // Register widths
    localparam int GAIN_W     = 24;
    localparam int ACCEL_W    = 31;
    localparam int FLOOR_W    = 32;
    localparam int CEIL_W     = 31;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Step time field width and scale
    localparam int STEP_W = 20;
    localparam logic [STEP_W-1:0] MICROS_PER_S = 20'd1000000;

    // Gain is Q8.16; gain squared carries twice the fraction bits
    localparam int GAIN_FRAC  = 16;
    localparam int DIST_SHIFT = 2 * GAIN_FRAC;

    // Register indexes of the write port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN  = 2'd0,
        REG_ACCEL = 2'd1,
        REG_FLOOR = 2'd2,
        REG_CEIL  = 2'd3
    } spc_reg_idx_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/spc_front.sv =====
module spc_front #(
    parameter int DATA_WIDTH = spc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic signed [DATA_WIDTH-1:0]        target_position,
    input  logic signed [DATA_WIDTH-1:0]        measured_position,
    input  logic [spc_pkg::STEP_W-1:0]          step_time_us,
    input  logic signed [spc_pkg::FLOOR_W-1:0]  error_floor,
    input  logic [spc_pkg::CEIL_W-1:0]          error_ceiling,
    output logic                                vld,
    output logic [DATA_WIDTH-1:0]               err,
    output logic [DATA_WIDTH-1:0]               mag,
    output logic                                neg,
    output logic [spc_pkg::STEP_W-1:0]          dt
);

    localparam int CMP_W = spc_pkg::max_int(DATA_WIDTH, spc_pkg::FLOOR_W) + 1;

    logic signed [DATA_WIDTH:0]     diff;
    logic                           ovf;
    logic signed [DATA_WIDTH-1:0]   sat_err;
    logic signed [CMP_W-1:0]        sat_x;
    logic signed [CMP_W-1:0]        floor_x;
    logic signed [CMP_W-1:0]        ceil_x;
    logic signed [CMP_W-1:0]        clamp_x;
    logic [DATA_WIDTH-1:0]          err_next;
    logic [DATA_WIDTH-1:0]          mag_next;
    logic                           vld_reg;
    logic [DATA_WIDTH-1:0]          err_reg;
    logic [DATA_WIDTH-1:0]          mag_reg;
    logic                           neg_reg;
    logic [spc_pkg::STEP_W-1:0]     dt_reg;

    // Form the error and saturate it to the data width
    assign diff = {target_position[DATA_WIDTH-1], target_position}
                - {measured_position[DATA_WIDTH-1], measured_position};
    assign ovf = diff[DATA_WIDTH] ^ diff[DATA_WIDTH-1];
    assign sat_err = ovf ? {diff[DATA_WIDTH], {(DATA_WIDTH-1){~diff[DATA_WIDTH]}}}
                         : diff[DATA_WIDTH-1:0];

    // Clamp against the active error limits
    assign sat_x   = CMP_W'(sat_err);
    assign floor_x = CMP_W'(error_floor);
    assign ceil_x  = CMP_W'({1'b0, error_ceiling});

    always_comb
    begin
        priority if (floor_x[CMP_W-1] && (sat_x < floor_x))
        begin
            clamp_x = floor_x;
        end
        else if ((error_ceiling != '0) && (sat_x > ceil_x))
        begin
            clamp_x = ceil_x;
        end
        else
        begin
            clamp_x = sat_x;
        end
    end

    assign err_next = clamp_x[DATA_WIDTH-1:0];
    assign mag_next = err_next[DATA_WIDTH-1] ? (~err_next + 1'b1) : err_next;

    // Hold request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_valid;
        end
    end

    // Capture error, magnitude and step time
    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        mag_reg <= mag_next;
        neg_reg <= err_next[DATA_WIDTH-1];
        dt_reg  <= step_time_us;
    end

    assign vld = vld_reg;
    assign err = err_reg;
    assign mag = mag_reg;
    assign neg = neg_reg;
    assign dt  = dt_reg;

endmodule

// ===== design/spc_div_cell.sv =====
module spc_div_cell #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic [DEN_W-1:0] rem_in,
    input  logic [NUM_W-1:0] quo_in,
    input  logic [DEN_W-1:0] den,
    output logic [DEN_W-1:0] rem_out,
    output logic [NUM_W-1:0] quo_out
);

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;

    // Bring down the next dividend bit and try a subtract
    assign trial = {rem_in, quo_in[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign ge    = (trial >= {1'b0, den});

    assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quo_next = {quo_in[NUM_W-2:0], ge};

    // Advance to the neighbor
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

// ===== design/spc_sqrt_cell.sv =====
module spc_sqrt_cell #(
    parameter int ROOT_W = 32
) (
    input  logic                  clk,
    input  logic [2*ROOT_W-1:0]   rad_in,
    input  logic [ROOT_W+1:0]     rem_in,
    input  logic [ROOT_W-1:0]     root_in,
    output logic [2*ROOT_W-1:0]   rad_out,
    output logic [ROOT_W+1:0]     rem_out,
    output logic [ROOT_W-1:0]     root_out
);

    logic [ROOT_W+3:0]   shifted;
    logic [ROOT_W+3:0]   trial;
    logic [ROOT_W+3:0]   diff;
    logic                ge;
    logic [2*ROOT_W-1:0] rad_next;
    logic [ROOT_W+1:0]   rem_next;
    logic [ROOT_W-1:0]   root_next;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    // Bring down two radicand bits and test the next root bit
    assign shifted = {rem_in, rad_in[2*ROOT_W-1:2*ROOT_W-2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign diff    = shifted - trial;
    assign ge      = (shifted >= trial);

    assign rem_next  = ge ? diff[ROOT_W+1:0] : shifted[ROOT_W+1:0];
    assign root_next = {root_in[ROOT_W-2:0], ge};
    assign rad_next  = {rad_in[2*ROOT_W-3:0], 2'b00};

    // Advance to the neighbor
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

// ===== design/sqrt_position_controller_top.sv =====
// Square-root position controller. A request is taken whenever start is high; busy stays low,
// so one request may follow another in every cycle. The result (rate_cmd,
// clamped_error, rate_limited) is shown for exactly one cycle with done high.
// It is formed by two rows of cells: a restoring divider row one quotient bit per
// cell (DIV_N_W cells, 63 at the default width, forming accel/gain^2 and |error|*1e6/dt side
// by side) and a square-root row one root bit per cell (SQ_STEPS cells, 32 by default).
// Results come out in request order and cannot be held off. Registers are written through
// wr_en/wr_index/wr_data; the user must write them only while no request is in flight,
// which the block itself does not enforce.
module sqrt_position_controller_top #(
    parameter int DATA_WIDTH = spc_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [DATA_WIDTH-1:0]         target_position,
    input  logic signed [DATA_WIDTH-1:0]         measured_position,
    input  logic [spc_pkg::STEP_W-1:0]           step_time_us,
    input  logic                                 wr_en,
    input  logic [spc_pkg::REG_IDX_W-1:0]        wr_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]       wr_data,
    output logic                                 done,
    output logic signed [DATA_WIDTH-1:0]         rate_cmd,
    output logic signed [DATA_WIDTH-1:0]         clamped_error,
    output logic                                 rate_limited
);

    localparam int MW          = DATA_WIDTH;
    localparam int STEP_W      = spc_pkg::STEP_W;
    localparam int GSQ_W       = 2 * spc_pkg::GAIN_W;
    localparam int LIM_NUM_W   = MW + STEP_W;
    localparam int DIST_NUM_W  = spc_pkg::ACCEL_W + spc_pkg::DIST_SHIFT;
    localparam int DIV_N_W     = spc_pkg::max_int(DIST_NUM_W, LIM_NUM_W);
    localparam int OP_W        = MW + 1;
    localparam int RAD_W       = spc_pkg::ACCEL_W + OP_W;
    localparam int SQ_STEPS    = (RAD_W + 1) / 2;
    localparam int SQ_RAD_W    = 2 * SQ_STEPS;
    localparam int LIN_PROD_W  = MW + spc_pkg::GAIN_W;
    localparam int LIN_W       = LIN_PROD_W - spc_pkg::GAIN_FRAC;
    localparam int MAG_W       = spc_pkg::max_int(SQ_STEPS, LIN_W);

    // Divider row sideband: {err, m, neg, dt}
    localparam int DSB_W       = 2 * MW + 1 + STEP_W;
    localparam int DSB_NEG     = STEP_W;
    localparam int DSB_M_LO    = STEP_W + 1;
    localparam int DSB_ERR_LO  = STEP_W + 1 + MW;

    // Root row sideband: {err, neg, dtnz, use_sqrt, lin, lim}
    localparam int QSB_W       = MW + 3 + 2 * MAG_W;
    localparam int QSB_LIN_LO  = MAG_W;
    localparam int QSB_USE     = 2 * MAG_W;
    localparam int QSB_DTNZ    = 2 * MAG_W + 1;
    localparam int QSB_NEG     = 2 * MAG_W + 2;
    localparam int QSB_ERR_LO  = 2 * MAG_W + 3;

    // Configuration registers
    logic [spc_pkg::GAIN_W-1:0]          gain_reg;
    logic [spc_pkg::ACCEL_W-1:0]         accel_reg;
    logic signed [spc_pkg::FLOOR_W-1:0]  floor_reg;
    logic [spc_pkg::CEIL_W-1:0]          ceil_reg;

    // Front stage outputs
    logic                     f_vld;
    logic [MW-1:0]            f_err;
    logic [MW-1:0]            f_mag;
    logic                     f_neg;
    logic [STEP_W-1:0]        f_dt;

    // Operand stage
    logic [LIM_NUM_W-1:0]     lim_prod_next;
    logic [GSQ_W-1:0]         gsq_next;
    logic                     v2_reg;
    logic [DSB_W-1:0]         sb2_reg;
    logic [DIV_N_W-1:0]       lim_num_reg;
    logic [GSQ_W-1:0]         gsq_reg;
    logic [DIV_N_W-1:0]       dist_num;

    // Divider row
    logic [GSQ_W-1:0]         d_rem [1:DIV_N_W];
    logic [DIV_N_W-1:0]       d_quo [1:DIV_N_W];
    logic [STEP_W-1:0]        l_rem [1:DIV_N_W];
    logic [DIV_N_W-1:0]       l_quo [1:DIV_N_W];
    logic                     dv    [1:DIV_N_W];
    logic [DSB_W-1:0]         dsb   [1:DIV_N_W];

    // Radicand select stage
    logic [MW-1:0]            p_m;
    logic [DIV_N_W-1:0]       p_dist;
    logic [DIV_N_W-1:0]       p_lim;
    logic [OP_W-1:0]          p_two_m;
    logic                     p_gt;
    logic [OP_W-1:0]          p_op_next;
    logic                     p_use_next;
    logic [MAG_W-1:0]         p_lim_next;
    logic                     pv_reg;
    logic [MW-1:0]            p_err_reg;
    logic [MW-1:0]            p_m_reg;
    logic                     p_neg_reg;
    logic                     p_dtnz_reg;
    logic [OP_W-1:0]          p_op_reg;
    logic                     p_use_reg;
    logic [MAG_W-1:0]         p_lim_reg;

    // Multiply stage
    logic [RAD_W-1:0]         rad_next;
    logic [LIN_PROD_W-1:0]    lin_prod_next;
    logic                     qv_reg;
    logic [SQ_RAD_W-1:0]      q_rad_reg;
    logic [QSB_W-1:0]         q_sb_reg;

    // Root row
    logic [SQ_RAD_W-1:0]      s_rad  [1:SQ_STEPS];
    logic [SQ_STEPS+1:0]      s_rem  [1:SQ_STEPS];
    logic [SQ_STEPS-1:0]      s_root [1:SQ_STEPS];
    logic                     sv     [1:SQ_STEPS];
    logic [QSB_W-1:0]         ssb    [1:SQ_STEPS];

    // Step clamp stage
    logic [QSB_W-1:0]         e_sb;
    logic [MAG_W-1:0]         e_mag_raw;
    logic                     e_over_next;
    logic [MAG_W-1:0]         e_mag_next;
    logic                     ev_reg;
    logic [MAG_W-1:0]         e_mag_reg;
    logic                     e_neg_reg;
    logic [MW-1:0]            e_err_reg;
    logic                     e_lim_reg;

    // Output stage
    logic [MAG_W-1:0]         sat_lim;
    logic [MAG_W-1:0]         mag_sat;
    logic [MW-1:0]            rate_mag;
    logic [MW-1:0]            rate_next;
    logic                     done_reg;
    logic [MW-1:0]            rate_reg;
    logic [MW-1:0]            cerr_reg;
    logic                     limited_reg;

    // Every cell advances in every cycle, so a request is always taken
    assign busy = 1'b0;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            accel_reg <= '0;
            floor_reg <= '0;
            ceil_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (spc_pkg::spc_reg_idx_t'(wr_index))
                spc_pkg::REG_GAIN:  gain_reg  <= wr_data[spc_pkg::GAIN_W-1:0];
                spc_pkg::REG_ACCEL: accel_reg <= wr_data[spc_pkg::ACCEL_W-1:0];
                spc_pkg::REG_FLOOR: floor_reg <= wr_data[spc_pkg::FLOOR_W-1:0];
                spc_pkg::REG_CEIL:  ceil_reg  <= wr_data[spc_pkg::CEIL_W-1:0];
            endcase
        end
    end

    // Form and clamp the error
    spc_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (start & ~busy),
        .target_position   (target_position),
        .measured_position (measured_position),
        .step_time_us      (step_time_us),
        .error_floor       (floor_reg),
        .error_ceiling     (ceil_reg),
        .vld               (f_vld),
        .err               (f_err),
        .mag               (f_mag),
        .neg               (f_neg),
        .dt                (f_dt)
    );

    // Build divider operands
    assign lim_prod_next = LIM_NUM_W'(f_mag) * LIM_NUM_W'(spc_pkg::MICROS_PER_S);
    assign gsq_next      = GSQ_W'(gain_reg) * GSQ_W'(gain_reg);
    assign dist_num      = DIV_N_W'(accel_reg) << spc_pkg::DIST_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= f_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        sb2_reg     <= {f_err, f_mag, f_neg, f_dt};
        lim_num_reg <= DIV_N_W'(lim_prod_next);
        gsq_reg     <= gsq_next;
    end

    // Divider row: one quotient bit of each division per cell
    for (genvar k = 0; k < DIV_N_W; k++)
    begin : g_div
        logic [GSQ_W-1:0]   drem_in;
        logic [DIV_N_W-1:0] dquo_in;
        logic [STEP_W-1:0]  lrem_in;
        logic [DIV_N_W-1:0] lquo_in;
        logic               v_in;
        logic [DSB_W-1:0]   sb_in;

        if (k == 0)
        begin : g_first
            assign drem_in = '0;
            assign dquo_in = dist_num;
            assign lrem_in = '0;
            assign lquo_in = lim_num_reg;
            assign v_in    = v2_reg;
            assign sb_in   = sb2_reg;
        end
        else
        begin : g_next
            assign drem_in = d_rem[k];
            assign dquo_in = d_quo[k];
            assign lrem_in = l_rem[k];
            assign lquo_in = l_quo[k];
            assign v_in    = dv[k];
            assign sb_in   = dsb[k];
        end

        spc_div_cell #(
            .NUM_W (DIV_N_W),
            .DEN_W (GSQ_W)
        ) u_dist (
            .clk     (clk),
            .rem_in  (drem_in),
            .quo_in  (dquo_in),
            .den     (gsq_reg),
            .rem_out (d_rem[k+1]),
            .quo_out (d_quo[k+1])
        );

        spc_div_cell #(
            .NUM_W (DIV_N_W),
            .DEN_W (STEP_W)
        ) u_lim (
            .clk     (clk),
            .rem_in  (lrem_in),
            .quo_in  (lquo_in),
            .den     (sb_in[STEP_W-1:0]),
            .rem_out (l_rem[k+1]),
            .quo_out (l_quo[k+1])
        );

        // Advance valid and sideband with the cell
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv[k+1] <= 1'b0;
            end
            else
            begin
                dv[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dsb[k+1] <= sb_in;
        end
    end

    // Pick the mode and the square-root operand
    assign p_m     = dsb[DIV_N_W][DSB_M_LO +: MW];
    assign p_dist  = d_quo[DIV_N_W];
    assign p_lim   = l_quo[DIV_N_W];
    assign p_two_m = {p_m, 1'b0};
    assign p_gt    = (DIV_N_W'(p_m) > p_dist);

    assign p_op_next  = (gain_reg == '0) ? p_two_m : (p_two_m - p_dist[OP_W-1:0]);
    assign p_use_next = (accel_reg != '0) && ((gain_reg == '0) || p_gt);
    assign p_lim_next = (p_lim > DIV_N_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}}
                                                           : p_lim[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= dv[DIV_N_W];
        end
    end

    always_ff @(posedge clk)
    begin
        p_err_reg  <= dsb[DIV_N_W][DSB_ERR_LO +: MW];
        p_m_reg    <= p_m;
        p_neg_reg  <= dsb[DIV_N_W][DSB_NEG];
        p_dtnz_reg <= (dsb[DIV_N_W][STEP_W-1:0] != '0);
        p_op_reg   <= p_op_next;
        p_use_reg  <= p_use_next;
        p_lim_reg  <= p_lim_next;
    end

    // Multiply out the radicand and the linear rate
    assign rad_next      = RAD_W'(accel_reg) * RAD_W'(p_op_reg);
    assign lin_prod_next = LIN_PROD_W'(p_m_reg) * LIN_PROD_W'(gain_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg <= 1'b0;
        end
        else
        begin
            qv_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_rad_reg <= SQ_RAD_W'(rad_next);
        q_sb_reg  <= {p_err_reg, p_neg_reg, p_dtnz_reg, p_use_reg,
                      MAG_W'(lin_prod_next[LIN_PROD_W-1:spc_pkg::GAIN_FRAC]), p_lim_reg};
    end

    // Root row: one root bit per cell
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        logic [SQ_RAD_W-1:0] rad_in;
        logic [SQ_STEPS+1:0] rem_in;
        logic [SQ_STEPS-1:0] root_in;
        logic                v_in;
        logic [QSB_W-1:0]    sb_in;

        if (j == 0)
        begin : g_first
            assign rad_in  = q_rad_reg;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = qv_reg;
            assign sb_in   = q_sb_reg;
        end
        else
        begin : g_next
            assign rad_in  = s_rad[j];
            assign rem_in  = s_rem[j];
            assign root_in = s_root[j];
            assign v_in    = sv[j];
            assign sb_in   = ssb[j];
        end

        spc_sqrt_cell #(
            .ROOT_W (SQ_STEPS)
        ) u_cell (
            .clk      (clk),
            .rad_in   (rad_in),
            .rem_in   (rem_in),
            .root_in  (root_in),
            .rad_out  (s_rad[j+1]),
            .rem_out  (s_rem[j+1]),
            .root_out (s_root[j+1])
        );

        // Advance valid and sideband with the cell
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv[j+1] <= 1'b0;
            end
            else
            begin
                sv[j+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            ssb[j+1] <= sb_in;
        end
    end

    // Select the rate and apply the step-time clamp
    assign e_sb        = ssb[SQ_STEPS];
    assign e_mag_raw   = e_sb[QSB_USE] ? MAG_W'(s_root[SQ_STEPS]) : e_sb[QSB_LIN_LO +: MAG_W];
    assign e_over_next = e_sb[QSB_DTNZ] && (e_mag_raw > e_sb[MAG_W-1:0]);
    assign e_mag_next  = e_over_next ? e_sb[MAG_W-1:0] : e_mag_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
        end
        else
        begin
            ev_reg <= sv[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        e_mag_reg <= e_mag_next;
        e_neg_reg <= e_sb[QSB_NEG];
        e_err_reg <= e_sb[QSB_ERR_LO +: MW];
        e_lim_reg <= e_over_next;
    end

    // Saturate and apply the sign
    assign sat_lim   = e_neg_reg ? (MAG_W'(1) << (MW - 1)) : MAG_W'({(MW-1){1'b1}});
    assign mag_sat   = (e_mag_reg > sat_lim) ? sat_lim : e_mag_reg;
    assign rate_mag  = mag_sat[MW-1:0];
    assign rate_next = e_neg_reg ? (~rate_mag + 1'b1) : rate_mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ev_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg    <= rate_next;
        cerr_reg    <= e_err_reg;
        limited_reg <= e_lim_reg;
    end

    assign done            = done_reg;
    assign rate_cmd        = rate_reg;
    assign clamped_error   = cerr_reg;
    assign rate_limited    = limited_reg;

    // The output stage strobes in the cycle after the clamp stage holds a request
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ev_reg |=> done)
        else $error("result strobe missing after clamp stage");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ev_reg))
        else $error("result strobe without a request in the clamp stage");

    // Zero error gives zero rate and no step clamp
    a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (clamped_error == '0)) |-> ((rate_cmd == '0) && !rate_limited))
        else $error("nonzero rate for zero error");

    // A non-negative error never gives a negative rate
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !clamped_error[MW-1]) |-> !rate_cmd[MW-1])
        else $error("rate sign disagrees with error sign");

endmodule

// ===== sim/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = spc_pkg::DATA_WIDTH_DEF;
    localparam int LATENCY = 101;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] rate;
        logic signed [DW-1:0] err;
        logic                 limited;
    } rate_result_t;

    // Controller model: settings plus one stateless step
    class rate_scoreboard;
        logic [spc_pkg::GAIN_W-1:0]         kp;
        logic [spc_pkg::ACCEL_W-1:0]        accel;
        logic signed [spc_pkg::FLOOR_W-1:0] floor_lim;
        logic [spc_pkg::CEIL_W-1:0]         ceil_lim;
        rate_result_t                       pending[$];
        int                                 fails;

        function new();
            kp = '0;
            accel = '0;
            floor_lim = '0;
            ceil_lim = '0;
            fails = 0;
        endfunction

        function longint unsigned isqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned cand;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                cand = r | (64'd1 << b);
                if (cand * cand <= v)
                    r = cand;
            end
            return isqrt_done(r);
        endfunction

        function longint unsigned isqrt_done(longint unsigned r);
            return r;
        endfunction

        function rate_result_t predict(logic signed [DW-1:0] tgt, logic signed [DW-1:0] meas,
                                       logic [spc_pkg::STEP_W-1:0] dt);
            longint                 e;
            longint unsigned        m;
            longint unsigned        mag;
            longint unsigned        lin_span;
            longint unsigned        lim;
            logic                   neg;
            rate_result_t           res;
            e = longint'(tgt) - longint'(meas);
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (e < -64'sd2147483648) e = -64'sd2147483648;
            if (floor_lim < 0 && e < longint'(floor_lim))
                e = longint'(floor_lim);
            else if (ceil_lim != 0 && e > longint'({1'b0, ceil_lim}))
                e = longint'({1'b0, ceil_lim});
            neg = e < 0;
            m = neg ? longint'(-e) : longint'(e);
            if (accel == 0)
                mag = (m * kp) >> spc_pkg::GAIN_FRAC;
            else if (kp == 0)
                mag = isqrt(2 * longint'(accel) * m);
            else
            begin
                lin_span = (longint'(accel) << 32) / (longint'(kp) * longint'(kp));
                if (m > lin_span)
                    mag = isqrt(longint'(accel) * (2 * m - lin_span));
                else
                    mag = (m * kp) >> spc_pkg::GAIN_FRAC;
            end
            res.limited = 1'b0;
            if (dt != 0)
            begin
                lim = (m * 64'd1000000) / dt;
                if (mag > lim)
                begin
                    mag = lim;
                    res.limited = 1'b1;
                end
            end
            if (neg)
            begin
                if (mag > 64'd2147483648) mag = 64'd2147483648;
                res.rate = DW'(-longint'(mag));
            end
            else
            begin
                if (mag > 64'd2147483647) mag = 64'd2147483647;
                res.rate = DW'(mag);
            end
            res.err = DW'(e);
            return res;
        endfunction

        // Note one accepted request
        function void note_request(logic signed [DW-1:0] tgt, logic signed [DW-1:0] meas,
                                   logic [spc_pkg::STEP_W-1:0] dt);
            pending.push_back(predict(tgt, meas, dt));
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(rate_result_t got);
            rate_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result rate=%0d err=%0d limited=%0d",
                         $realtime, got.rate, got.err, got.limited);
                fails++;
                return;
            end
            want = pending.pop_front();
            if (got.rate !== want.rate)
            begin
                $display("%0t: rate_cmd expected %0d actual %0d",
                         $realtime, want.rate, got.rate);
                fails++;
            end
            if (got.err !== want.err)
            begin
                $display("%0t: clamped_error expected %0d actual %0d",
                         $realtime, want.err, got.err);
                fails++;
            end
            if (got.limited !== want.limited)
            begin
                $display("%0t: rate_limited expected %0d actual %0d",
                         $realtime, want.limited, got.limited);
                fails++;
            end
        endfunction
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic signed [DW-1:0]               target_position = '0;
    logic signed [DW-1:0]               measured_position = '0;
    logic [spc_pkg::STEP_W-1:0]         step_time_us = '0;
    logic                               wr_en = 1'b0;
    logic [spc_pkg::REG_IDX_W-1:0]      wr_index = '0;
    logic [spc_pkg::CFG_DATA_W-1:0]     wr_data = '0;
    logic                               done;
    logic signed [DW-1:0]               rate_cmd;
    logic signed [DW-1:0]               clamped_error;
    logic                               rate_limited;

    rate_scoreboard sb = new();
    int             idle_pct = 0;
    int             cycles = 0;

    sqrt_position_controller_top #(.DATA_WIDTH(DW)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .target_position(target_position), .measured_position(measured_position),
        .step_time_us(step_time_us), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .done(done), .rate_cmd(rate_cmd),
        .clamped_error(clamped_error), .rate_limited(rate_limited)
    );

    always #6 clk = ~clk;

    // Watch both handshakes and the cycle budget
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
            sb.note_request(target_position, measured_position, step_time_us);
        if (rst_n && done)
            sb.check_result('{rate_cmd, clamped_error, rate_limited});
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one register and mirror it in the model
    task automatic write_reg(spc_pkg::spc_reg_idx_t idx, logic [spc_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            spc_pkg::REG_GAIN:  sb.kp = value[spc_pkg::GAIN_W-1:0];
            spc_pkg::REG_ACCEL: sb.accel = value[spc_pkg::ACCEL_W-1:0];
            spc_pkg::REG_FLOOR: sb.floor_lim = value;
            spc_pkg::REG_CEIL:  sb.ceil_lim = value[spc_pkg::CEIL_W-1:0];
        endcase
    endtask

    task automatic configure(logic [spc_pkg::GAIN_W-1:0] kp, logic [spc_pkg::ACCEL_W-1:0] acc,
                             logic signed [spc_pkg::FLOOR_W-1:0] fl,
                             logic [spc_pkg::CEIL_W-1:0] cl);
        write_reg(spc_pkg::REG_GAIN, spc_pkg::CFG_DATA_W'(kp));
        write_reg(spc_pkg::REG_ACCEL, spc_pkg::CFG_DATA_W'(acc));
        write_reg(spc_pkg::REG_FLOOR, fl);
        write_reg(spc_pkg::REG_CEIL, spc_pkg::CFG_DATA_W'(cl));
    endtask

    // Hold off until every result is in and the pipe is empty
    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // Issue one request, then possibly idle for a random run of cycles
    task automatic send_request(logic signed [DW-1:0] tgt, logic signed [DW-1:0] meas,
                                logic [spc_pkg::STEP_W-1:0] dt);
        @(posedge clk);
        start <= 1'b1;
        target_position <= tgt;
        measured_position <= meas;
        step_time_us <= dt;
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            @(posedge clk);
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic stop_requests();
        @(posedge clk);
        start <= 1'b0;
    endtask

    task automatic random_request();
        logic signed [DW-1:0]        meas;
        logic signed [DW-1:0]        tgt;
        logic [spc_pkg::STEP_W-1:0]  dt;
        meas = $urandom;
        case ($urandom_range(3))
            0: tgt = $urandom;
            1: tgt = meas + $signed($urandom_range(8191)) - 4096;
            2: tgt = meas + $signed($urandom_range(2000000)) - 1000000;
            default: tgt = meas;
        endcase
        if ($urandom_range(9) == 0)
            tgt = meas;
        case ($urandom_range(3))
            0: dt = '0;
            1: dt = spc_pkg::STEP_W'($urandom_range(1, 100));
            2: dt = spc_pkg::STEP_W'($urandom_range(1000, 50000));
            default: dt = spc_pkg::STEP_W'($urandom);
        endcase
        send_request(tgt, meas, dt);
    endtask

    initial
    begin
        logic [spc_pkg::GAIN_W-1:0]         kp;
        logic [spc_pkg::ACCEL_W-1:0]        acc;
        logic signed [spc_pkg::FLOOR_W-1:0] fl;
        logic [spc_pkg::CEIL_W-1:0]         cl;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: both limits zero, then further settings with gains, accelerations and clamps
        send_request(32'sd1000, 32'sd0, 20'd0);
        send_request(32'sh7fffffff, 32'sh80000000, 20'd0);
        send_request(32'sh80000000, 32'sh7fffffff, 20'd1);
        send_request(32'sd5, 32'sd5, 20'd10);
        stop_requests();
        drain();
        configure(24'h010000, 31'd0, 32'sd0, 31'd0);
        send_request(32'sd1000, 32'sd0, 20'd0);
        send_request(-32'sd1000, 32'sd0, 20'hfffff);
        send_request(32'sh7fffffff, 32'sh80000000, 20'd1);
        stop_requests();
        drain();
        configure(24'd0, 31'd25600, -32'sd100000, 31'd100000);
        send_request(32'sd50000, 32'sd0, 20'd0);
        send_request(32'sd0, 32'sd500000, 20'd0);
        send_request(32'sd500000, 32'sd0, 20'd1000);
        send_request(32'sd0, 32'sd0, 20'd1000);
        stop_requests();
        drain();
        configure(24'hffffff, 31'h7fffffff, 32'sh80000000, 31'h7fffffff);
        send_request(32'sh7fffffff, 32'sh80000000, 20'd0);
        send_request(32'sh80000000, 32'sh7fffffff, 20'd0);
        send_request(32'sd3, 32'sd0, 20'd7);
        send_request(-32'sd3, 32'sd0, 20'hfffff);
        stop_requests();
        drain();
        configure(24'h008000, 31'd51200, -32'sd256, 31'd256);
        send_request(32'sd100000, 32'sd0, 20'd0);
        send_request(-32'sd100000, 32'sd0, 20'd50);
        send_request(32'sd100, 32'sd0, 20'd20000);
        send_request(32'sd1, 32'sd0, 20'd0);
        stop_requests();
        drain();

        // Random phases over idle patterns and settings
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 84;
                2: idle_pct = 0;
                default: idle_pct = 24;
            endcase
            kp = ($urandom_range(3) == 0) ? 24'd0 :
                 ($urandom_range(3) == 0) ? 24'hffffff
                                          : spc_pkg::GAIN_W'($urandom_range(16777215));
            acc = ($urandom_range(3) == 0) ? 31'd0 :
                  ($urandom_range(3) == 0) ? 31'h7fffffff
                                           : spc_pkg::ACCEL_W'($urandom_range(1 << 24));
            fl = ($urandom_range(1) == 0) ? 32'sd0
                 : spc_pkg::FLOOR_W'(-$signed({1'b0, $urandom_range(1 << 30)}));
            cl = ($urandom_range(1) == 0) ? 31'd0
                 : spc_pkg::CEIL_W'($urandom_range(1 << 30));
            if (ph == 7)
                fl = 32'sh80000000;
            configure(kp, acc, fl, cl);
            for (int i = 0; i < 180; i++)
            begin
                random_request();
                if (ph == 3 && i == 90)
                begin
                    stop_requests();
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
            end
            stop_requests();
            drain();
        end

        if (sb.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/spc_pkg.sv
design/spc_front.sv
design/spc_div_cell.sv
design/spc_sqrt_cell.sv
design/sqrt_position_controller_top.sv
sim/testbench.sv
